// ===== rtl/assert_macros.svh =====
// Assertion helpers shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH

`define FRF_ASSERT_IMPL(name, clk, rstn, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("same-cycle check failed");

`define FRF_ASSERT_NEXT(name, clk, rstn, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`else

`define FRF_ASSERT_IMPL(name, clk, rstn, ante, cons)

`define FRF_ASSERT_NEXT(name, clk, rstn, ante, cons)

`endif

`endif

// ===== rtl/frf_pkg.sv =====
package frf_pkg;

    localparam int RelayEntries = 8;
    localparam int TripleW      = 24;
    localparam int HdrBytes     = 5;

    // configuration register indexes
    localparam logic [2:0] CFG_NODE_ID   = 3'd0;
    localparam logic [2:0] CFG_IS_PARENT = 3'd1;
    localparam logic [2:0] CFG_PREAMBLE  = 3'd2;
    localparam logic [2:0] CFG_HOP_LIMIT = 3'd3;

    // header bytes replayed after a relay decision
    localparam logic [2:0] HDR_PREAMBLE = 3'd0;
    localparam logic [2:0] HDR_TYPE     = 3'd1;
    localparam logic [2:0] HDR_DEST     = 3'd2;
    localparam logic [2:0] HDR_SOURCE   = 3'd3;
    localparam logic [2:0] HDR_HOP      = 3'd4;

    localparam logic KIND_BYTE   = 1'b0;
    localparam logic KIND_REPORT = 1'b1;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_TYPE,
        ST_DEST,
        ST_SOURCE,
        ST_HOP,
        ST_SEARCH,
        ST_HDR,
        ST_LENGTH,
        ST_BODY,
        ST_REPORT
    } frf_state_t;

    typedef struct packed {
        logic               vld;
        logic               hit;
        logic [TripleW-1:0] key;
    } frf_probe_t;

    typedef struct packed {
        logic               vld;
        logic [TripleW-1:0] key;
    } frf_entry_t;

    typedef struct packed {
        logic               search;
        logic               insert;
        logic [TripleW-1:0] triple;
    } frf_tbl_req_t;

    typedef struct packed {
        logic done;
        logic hit;
    } frf_tbl_rsp_t;

endpackage

// ===== rtl/frf_cell.sv =====
module frf_cell (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                insert,
    input  frf_pkg::frf_probe_t probe_in,
    output frf_pkg::frf_probe_t probe_out,
    input  frf_pkg::frf_entry_t entry_in,
    output frf_pkg::frf_entry_t entry_out
);

    logic                        probe_vld_reg;
    logic                        probe_hit_reg;
    logic                        probe_hit_next;
    logic [frf_pkg::TripleW-1:0] probe_key_reg;
    logic                        entry_vld_reg;
    logic [frf_pkg::TripleW-1:0] entry_key_reg;

    assign probe_hit_next = probe_in.hit
                          | (entry_vld_reg && (entry_key_reg == probe_in.key));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            probe_vld_reg <= 1'b0;
            entry_vld_reg <= 1'b0;
        end else begin
            probe_vld_reg <= probe_in.vld;
            if (insert) begin
                entry_vld_reg <= entry_in.vld;
            end
        end
    end

    // shift the entry one cell down on insert; the oldest falls off the end
    always_ff @(posedge aclk) begin
        probe_hit_reg <= probe_hit_next;
        probe_key_reg <= probe_in.key;
        if (insert) begin
            entry_key_reg <= entry_in.key;
        end
    end

    assign probe_out.vld = probe_vld_reg;
    assign probe_out.hit = probe_hit_reg;
    assign probe_out.key = probe_key_reg;
    assign entry_out.vld = entry_vld_reg;
    assign entry_out.key = entry_key_reg;

endmodule

// ===== rtl/frf_table.sv =====
module frf_table (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  frf_pkg::frf_tbl_req_t req,
    output frf_pkg::frf_tbl_rsp_t rsp
);

    frf_pkg::frf_probe_t probe_link [0:frf_pkg::RelayEntries];
    frf_pkg::frf_entry_t entry_link [0:frf_pkg::RelayEntries-1];

    assign probe_link[0].vld = req.search;
    assign probe_link[0].hit = 1'b0;
    assign probe_link[0].key = req.triple;
    assign entry_link[0].vld = 1'b1;
    assign entry_link[0].key = req.triple;

    for (genvar i = 0; i < frf_pkg::RelayEntries; i++) begin : g_cell
        if (i < frf_pkg::RelayEntries - 1) begin : g_mid
            frf_cell u_cell (
                .aclk      (aclk),
                .aresetn   (aresetn),
                .insert    (req.insert),
                .probe_in  (probe_link[i]),
                .probe_out (probe_link[i+1]),
                .entry_in  (entry_link[i]),
                .entry_out (entry_link[i+1])
            );
        end else begin : g_last
            frf_cell u_cell (
                .aclk      (aclk),
                .aresetn   (aresetn),
                .insert    (req.insert),
                .probe_in  (probe_link[i]),
                .probe_out (probe_link[i+1]),
                .entry_in  (entry_link[i]),
                .entry_out ()
            );
        end
    end

    assign rsp.done = probe_link[frf_pkg::RelayEntries].vld;
    assign rsp.hit  = probe_link[frf_pkg::RelayEntries].hit;

endmodule

// ===== rtl/flood_relay_frame_filter_unit.sv =====
// Channel   Ports                          Carries
// s_        s_valid s_ready s_rx_byte      received radio byte
// m_        m_valid m_ready m_*            relayed byte or end-of-frame report
// cfg_      cfg_we cfg_index cfg_wdata     register write, no wait
//
// Idle, type, destination and source states always accept a byte.
// The hop byte launches a probe down the relay cell row, unless the node is a parent,
// the frame is for this node or the hop count has reached the limit; on a miss in
// the row the five header bytes are replayed. Length and body bytes are accepted
// when the output register is free; the frame end then emits the report.
// Synchronous active-low reset empties the relay row and returns to idle.
// A stalled m_ side holds one result and stops s_ from the length byte to the frame end.
`include "assert_macros.svh"

module flood_relay_frame_filter_unit (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [7:0] s_rx_byte,
    output logic       m_valid,
    input  logic       m_ready,
    output logic       m_result_kind,
    output logic [7:0] m_tx_byte,
    output logic       m_last_tx_byte,
    output logic       m_addressed_here,
    output logic       m_was_relayed,
    output logic       m_was_duplicate,
    output logic       m_hop_exceeded,
    output logic [7:0] m_frame_type,
    output logic [7:0] m_dest_id,
    output logic [7:0] m_source_id,
    output logic [7:0] m_body_length,
    input  logic       cfg_we,
    input  logic [2:0] cfg_index,
    input  logic [7:0] cfg_wdata
);

    frf_pkg::frf_state_t state_reg, state_next;

    logic [7:0] node_id_reg;
    logic       is_parent_reg;
    logic [7:0] preamble_reg;
    logic [7:0] hop_limit_reg;

    logic [7:0] type_reg, type_next;
    logic [7:0] dest_reg, dest_next;
    logic [7:0] source_reg, source_next;
    logic [7:0] hop_reg, hop_next;
    logic [7:0] length_reg, length_next;
    logic [7:0] left_reg, left_next;
    logic [2:0] hdr_cnt_reg, hdr_cnt_next;
    logic       relaying_reg, relaying_next;
    logic       here_reg, here_next;
    logic       was_relayed_reg, was_relayed_next;
    logic       dup_reg, dup_next;
    logic       hopex_reg, hopex_next;

    logic       m_valid_reg, m_valid_next;
    logic       m_result_kind_reg;
    logic [7:0] m_tx_byte_reg;
    logic       m_last_tx_byte_reg;
    logic       m_here_reg;
    logic       m_relayed_reg;
    logic       m_dup_reg;
    logic       m_hopex_reg;
    logic [7:0] m_type_reg;
    logic [7:0] m_dest_reg;
    logic [7:0] m_source_reg;
    logic [7:0] m_length_reg;

    logic       s_acc;
    logic       out_free;
    logic       emit_byte;
    logic       emit_last;
    logic [7:0] emit_value;
    logic       emit_report;

    frf_pkg::frf_tbl_req_t tbl_req;
    frf_pkg::frf_tbl_rsp_t tbl_rsp;

    frf_table u_table (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (tbl_req),
        .rsp     (tbl_rsp)
    );

    assign s_acc    = s_valid && s_ready;
    assign out_free = !m_valid_reg || m_ready;

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            frf_pkg::ST_IDLE: begin
                if (s_acc && (s_rx_byte == preamble_reg)) begin
                    state_next = frf_pkg::ST_TYPE;
                end
            end
            frf_pkg::ST_TYPE: begin
                if (s_acc) begin
                    state_next = frf_pkg::ST_DEST;
                end
            end
            frf_pkg::ST_DEST: begin
                if (s_acc) begin
                    state_next = frf_pkg::ST_SOURCE;
                end
            end
            frf_pkg::ST_SOURCE: begin
                if (s_acc) begin
                    state_next = frf_pkg::ST_HOP;
                end
            end
            frf_pkg::ST_HOP: begin
                if (s_acc) begin
                    state_next = tbl_req.search ? frf_pkg::ST_SEARCH : frf_pkg::ST_LENGTH;
                end
            end
            frf_pkg::ST_SEARCH: begin
                if (tbl_rsp.done) begin
                    state_next = tbl_rsp.hit ? frf_pkg::ST_LENGTH : frf_pkg::ST_HDR;
                end
            end
            frf_pkg::ST_HDR: begin
                if (out_free && (hdr_cnt_reg == 3'(frf_pkg::HdrBytes - 1))) begin
                    state_next = frf_pkg::ST_LENGTH;
                end
            end
            frf_pkg::ST_LENGTH: begin
                if (s_acc) begin
                    state_next = (s_rx_byte == 8'd0) ? frf_pkg::ST_REPORT : frf_pkg::ST_BODY;
                end
            end
            frf_pkg::ST_BODY: begin
                if (s_acc && (left_reg == 8'd1)) begin
                    state_next = frf_pkg::ST_REPORT;
                end
            end
            frf_pkg::ST_REPORT: begin
                if (out_free) begin
                    state_next = frf_pkg::ST_IDLE;
                end
            end
            default: state_next = frf_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        s_ready          = 1'b0;
        emit_byte        = 1'b0;
        emit_last        = 1'b0;
        emit_value       = 8'd0;
        emit_report      = 1'b0;
        tbl_req.search   = 1'b0;
        tbl_req.insert   = 1'b0;
        tbl_req.triple   = {source_reg, dest_reg, type_reg};
        type_next        = type_reg;
        dest_next        = dest_reg;
        source_next      = source_reg;
        hop_next         = hop_reg;
        length_next      = length_reg;
        left_next        = left_reg;
        hdr_cnt_next     = hdr_cnt_reg;
        relaying_next    = relaying_reg;
        here_next        = here_reg;
        was_relayed_next = was_relayed_reg;
        dup_next         = dup_reg;
        hopex_next       = hopex_reg;
        case (state_reg)
            frf_pkg::ST_IDLE: begin
                s_ready = 1'b1;
                if (s_acc && (s_rx_byte == preamble_reg)) begin
                    relaying_next    = 1'b0;
                    here_next        = 1'b0;
                    was_relayed_next = 1'b0;
                    dup_next         = 1'b0;
                    hopex_next       = 1'b0;
                end
            end
            frf_pkg::ST_TYPE: begin
                s_ready = 1'b1;
                if (s_acc) begin
                    type_next = s_rx_byte;
                end
            end
            frf_pkg::ST_DEST: begin
                s_ready = 1'b1;
                if (s_acc) begin
                    dest_next = s_rx_byte;
                end
            end
            frf_pkg::ST_SOURCE: begin
                s_ready = 1'b1;
                if (s_acc) begin
                    source_next = s_rx_byte;
                end
            end
            frf_pkg::ST_HOP: begin
                s_ready = 1'b1;
                if (s_acc) begin
                    here_next        = (dest_reg == node_id_reg);
                    was_relayed_next = 1'b0;
                    dup_next         = 1'b0;
                    hopex_next       = 1'b0;
                    relaying_next    = 1'b0;
                    hop_next         = s_rx_byte + 8'd1;
                    if (!is_parent_reg && (dest_reg != node_id_reg)) begin
                        if (s_rx_byte >= hop_limit_reg) begin
                            hopex_next = 1'b1;
                        end else begin
                            tbl_req.search = 1'b1;
                        end
                    end
                end
            end
            frf_pkg::ST_SEARCH: begin
                if (tbl_rsp.done) begin
                    if (tbl_rsp.hit) begin
                        dup_next = 1'b1;
                    end else begin
                        tbl_req.insert   = 1'b1;
                        was_relayed_next = 1'b1;
                        relaying_next    = 1'b1;
                        hdr_cnt_next     = frf_pkg::HDR_PREAMBLE;
                    end
                end
            end
            frf_pkg::ST_HDR: begin
                if (out_free) begin
                    emit_byte    = 1'b1;
                    hdr_cnt_next = hdr_cnt_reg + 3'd1;
                    case (hdr_cnt_reg)
                        frf_pkg::HDR_PREAMBLE: emit_value = preamble_reg;
                        frf_pkg::HDR_TYPE:     emit_value = type_reg;
                        frf_pkg::HDR_DEST:     emit_value = dest_reg;
                        frf_pkg::HDR_SOURCE:   emit_value = source_reg;
                        frf_pkg::HDR_HOP:      emit_value = hop_reg;
                        default:               emit_value = 8'd0;
                    endcase
                end
            end
            frf_pkg::ST_LENGTH: begin
                s_ready = out_free;
                if (s_acc) begin
                    length_next = s_rx_byte;
                    left_next   = s_rx_byte;
                    emit_byte   = relaying_reg;
                    emit_value  = s_rx_byte;
                    emit_last   = (s_rx_byte == 8'd0);
                end
            end
            frf_pkg::ST_BODY: begin
                s_ready = out_free;
                if (s_acc) begin
                    left_next  = left_reg - 8'd1;
                    emit_byte  = relaying_reg;
                    emit_value = s_rx_byte;
                    emit_last  = (left_reg == 8'd1);
                end
            end
            frf_pkg::ST_REPORT: begin
                if (out_free) begin
                    emit_report   = 1'b1;
                    relaying_next = 1'b0;
                end
            end
            default: begin
                s_ready = 1'b0;
            end
        endcase
    end

    always_comb begin
        if (emit_byte || emit_report) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= frf_pkg::ST_IDLE;
            node_id_reg   <= 8'd0;
            is_parent_reg <= 1'b0;
            preamble_reg  <= 8'd170;
            hop_limit_reg <= 8'd4;
            relaying_reg  <= 1'b0;
            hdr_cnt_reg   <= frf_pkg::HDR_PREAMBLE;
            m_valid_reg   <= 1'b0;
        end else begin
            state_reg    <= state_next;
            relaying_reg <= relaying_next;
            hdr_cnt_reg  <= hdr_cnt_next;
            m_valid_reg  <= m_valid_next;
            if (cfg_we) begin
                case (cfg_index)
                    frf_pkg::CFG_NODE_ID:   node_id_reg   <= cfg_wdata;
                    frf_pkg::CFG_IS_PARENT: is_parent_reg <= cfg_wdata[0];
                    frf_pkg::CFG_PREAMBLE:  preamble_reg  <= cfg_wdata;
                    frf_pkg::CFG_HOP_LIMIT: hop_limit_reg <= cfg_wdata;
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge aclk) begin
        type_reg        <= type_next;
        dest_reg        <= dest_next;
        source_reg      <= source_next;
        hop_reg         <= hop_next;
        length_reg      <= length_next;
        left_reg        <= left_next;
        here_reg        <= here_next;
        was_relayed_reg <= was_relayed_next;
        dup_reg         <= dup_next;
        hopex_reg       <= hopex_next;
        if (emit_report) begin
            m_result_kind_reg  <= frf_pkg::KIND_REPORT;
            m_tx_byte_reg      <= 8'd0;
            m_last_tx_byte_reg <= 1'b0;
            m_here_reg         <= here_reg;
            m_relayed_reg      <= was_relayed_reg;
            m_dup_reg          <= dup_reg;
            m_hopex_reg        <= hopex_reg;
            m_type_reg         <= type_reg;
            m_dest_reg         <= dest_reg;
            m_source_reg       <= source_reg;
            m_length_reg       <= length_reg;
        end else if (emit_byte) begin
            m_result_kind_reg  <= frf_pkg::KIND_BYTE;
            m_tx_byte_reg      <= emit_value;
            m_last_tx_byte_reg <= emit_last;
            m_here_reg         <= 1'b0;
            m_relayed_reg      <= 1'b0;
            m_dup_reg          <= 1'b0;
            m_hopex_reg        <= 1'b0;
            m_type_reg         <= 8'd0;
            m_dest_reg         <= 8'd0;
            m_source_reg       <= 8'd0;
            m_length_reg       <= 8'd0;
        end
    end

    assign m_valid          = m_valid_reg;
    assign m_result_kind    = m_result_kind_reg;
    assign m_tx_byte        = m_tx_byte_reg;
    assign m_last_tx_byte   = m_last_tx_byte_reg;
    assign m_addressed_here = m_here_reg;
    assign m_was_relayed    = m_relayed_reg;
    assign m_was_duplicate  = m_dup_reg;
    assign m_hop_exceeded   = m_hopex_reg;
    assign m_frame_type     = m_type_reg;
    assign m_dest_id        = m_dest_reg;
    assign m_source_id      = m_source_reg;
    assign m_body_length    = m_length_reg;

    `FRF_ASSERT_IMPL(a_done_only_in_search, aclk, aresetn,
                     tbl_rsp.done, state_reg == frf_pkg::ST_SEARCH)
    `FRF_ASSERT_NEXT(a_insert_marks_relay, aclk, aresetn,
                     tbl_req.insert, relaying_reg && was_relayed_reg)
    `FRF_ASSERT_IMPL(a_hdr_cnt_bound, aclk, aresetn,
                     state_reg == frf_pkg::ST_HDR, hdr_cnt_reg < 3'(frf_pkg::HdrBytes))
    `FRF_ASSERT_NEXT(a_report_then_idle, aclk, aresetn,
                     (state_reg == frf_pkg::ST_REPORT) && out_free,
                     (state_reg == frf_pkg::ST_IDLE) && m_valid_reg
                         && (m_result_kind_reg == frf_pkg::KIND_REPORT))
    `FRF_ASSERT_IMPL(a_no_rx_while_busy, aclk, aresetn,
                     (state_reg == frf_pkg::ST_SEARCH) || (state_reg == frf_pkg::ST_HDR)
                         || (state_reg == frf_pkg::ST_REPORT),
                     !s_ready)

endmodule
